[hw/rtl/chep_pkg.sv]
// Package for the convex hull extreme point unit: default sizes and the
// command / status structs passed between controller and datapath.
// No dependencies.
package chep_pkg;

  localparam int MAX_POINTS_DEF = 16;
  localparam int COORD_BITS_DEF = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;     // store the incoming point
    logic cap_i;     // read data holds point i
    logic cap_j;     // read data holds point j: form a, b and the c products
    logic calc_c;    // finish c, restart the side test
    logic test_v;    // read issued for a point k under test
    logic dedup_v;   // read issued for an earlier marked point
    logic cap_cand;  // read data holds the emission candidate
    logic push_pend; // send pending point on, candidate becomes pending
    logic set_pend;  // candidate becomes pending
    logic fin;       // send the closing result of the set
  } chep_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic agree;    // all tested points on one side of the line
    logic dup;      // candidate equals an earlier marked point
    logic pend_v;   // a point waits to be sent
    logic out_free; // output register can take a result this cycle
  } chep_sts_t;

endpackage

[hw/rtl/chep_if.sv]
// Valid/ready channel interfaces for point input and hull result output.
// No dependencies.
interface chep_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic                         last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

interface chep_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] hull_x;
  logic signed [COORD_BITS-1:0] hull_y;
  logic                         no_hull;
  logic                         final_result;

  modport source (output valid, output hull_x, output hull_y, output no_hull,
                  output final_result, input ready);
  modport sink   (input valid, input hull_x, input hull_y, input no_hull,
                  input final_result, output ready);
endinterface

[hw/rtl/chep_ram.sv]
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module chep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hw/rtl/chep_datapath.sv]
// Datapath: point store, line coefficients, pipelined side test, duplicate
// compare, pending point and output register. Uses chep_pkg and chep_ram.
module chep_datapath
  import chep_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chep_cmd_t                    cmd,
  input  logic [AW-1:0]                addr,
  input  logic signed [COORD_BITS-1:0] in_x,
  input  logic signed [COORD_BITS-1:0] in_y,
  input  logic                         out_ready,
  output chep_sts_t                    sts,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] hull_x,
  output logic signed [COORD_BITS-1:0] hull_y,
  output logic                         no_hull,
  output logic                         final_result
);

  localparam int CB  = COORD_BITS;
  localparam int DW  = 2 * CB;  // stored word {x, y}
  localparam int LW  = CB + 1;  // a and b
  localparam int PW  = 2 * CB;  // products forming c
  localparam int CCW = PW + 1;  // c
  localparam int MW  = LW + CB; // a*x and b*y
  localparam int SW  = MW + 2;  // side value

  logic [DW-1:0]           rd_data;
  logic signed [CB-1:0]    rd_x, rd_y;

  logic signed [CB-1:0]    xi_r, yi_r;
  logic signed [LW-1:0]    a_r, b_r;
  logic signed [PW-1:0]    m1_r, m2_r;
  logic signed [CCW-1:0]   c_r;
  logic signed [MW-1:0]    pa_r, pb_r;
  logic signed [SW-1:0]    side;
  logic                    side_neg;
  logic                    s1_test_r, s2_test_r, s1_dedup_r;
  logic                    seen_r, first_neg_r, agree_r, dup_r;
  logic signed [CB-1:0]    cand_x_r, cand_y_r, pend_x_r, pend_y_r;
  logic                    pend_v_r;
  logic                    out_valid_r, no_hull_r, final_r;
  logic signed [CB-1:0]    hull_x_r, hull_y_r;

  // Point store, one word per point
  chep_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (addr),
    .wr_data ({in_x, in_y}),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  assign rd_x = $signed(rd_data[DW-1:CB]);
  assign rd_y = $signed(rd_data[CB-1:0]);

  // Side of the line for the point in the last test stage
  assign side     = SW'(pa_r) + SW'(pb_r) - SW'(c_r);
  assign side_neg = side[SW-1];

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_test_r   <= 1'b0;
      s2_test_r   <= 1'b0;
      s1_dedup_r  <= 1'b0;
      seen_r      <= 1'b0;
      first_neg_r <= 1'b0;
      agree_r     <= 1'b0;
      dup_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_test_r  <= cmd.test_v;
      s2_test_r  <= s1_test_r;
      s1_dedup_r <= cmd.dedup_v;

      // side agreement over all tested points
      if (cmd.calc_c) begin
        seen_r  <= 1'b0;
        agree_r <= 1'b1;
      end else if (s2_test_r) begin
        if (!seen_r) begin
          seen_r      <= 1'b1;
          first_neg_r <= side_neg;
        end else if (side_neg != first_neg_r) begin
          agree_r <= 1'b0;
        end
      end

      // duplicate against earlier marked points
      if (cmd.cap_cand) begin
        dup_r <= 1'b0;
      end else if (s1_dedup_r && (rd_data == {cand_x_r, cand_y_r})) begin
        dup_r <= 1'b1;
      end

      if (cmd.fin) begin
        pend_v_r <= 1'b0;
      end else if (cmd.set_pend || cmd.push_pend) begin
        pend_v_r <= 1'b1;
      end

      if (cmd.push_pend || cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap_i) begin
      xi_r <= rd_x;
      yi_r <= rd_y;
    end
    if (cmd.cap_j) begin
      a_r  <= LW'(rd_y) - LW'(yi_r);
      b_r  <= LW'(xi_r) - LW'(rd_x);
      m1_r <= PW'(xi_r) * PW'(rd_y);
      m2_r <= PW'(yi_r) * PW'(rd_x);
    end
    if (cmd.calc_c) begin
      c_r <= CCW'(m1_r) - CCW'(m2_r);
    end
    if (s1_test_r) begin
      pa_r <= MW'(a_r) * MW'(rd_x);
      pb_r <= MW'(b_r) * MW'(rd_y);
    end
    if (cmd.cap_cand) begin
      cand_x_r <= rd_x;
      cand_y_r <= rd_y;
    end
    if (cmd.set_pend || cmd.push_pend) begin
      pend_x_r <= cand_x_r;
      pend_y_r <= cand_y_r;
    end
    if (cmd.push_pend) begin
      hull_x_r  <= pend_x_r;
      hull_y_r  <= pend_y_r;
      no_hull_r <= 1'b0;
      final_r   <= 1'b0;
    end else if (cmd.fin) begin
      hull_x_r  <= pend_v_r ? pend_x_r : '0;
      hull_y_r  <= pend_v_r ? pend_y_r : '0;
      no_hull_r <= !pend_v_r;
      final_r   <= 1'b1;
    end
  end

  assign sts.agree    = agree_r;
  assign sts.dup      = dup_r;
  assign sts.pend_v   = pend_v_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign hull_x       = hull_x_r;
  assign hull_y       = hull_y_r;
  assign no_hull      = no_hull_r;
  assign final_result = final_r;

endmodule

[hw/rtl/chep_ctrl.sv]
// Controller: load counter, pair / test / emission loop counters, hull marks
// and the state machine that sequences the datapath. Uses chep_pkg.
module chep_ctrl
  import chep_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_ready,
  input  chep_sts_t     sts,
  output chep_cmd_t     cmd,
  output logic [AW-1:0] addr
);

  localparam logic [3:0] ST_LOAD     = 4'd0;
  localparam logic [3:0] ST_RD_I     = 4'd1;
  localparam logic [3:0] ST_RD_J     = 4'd2;
  localparam logic [3:0] ST_CAP_J    = 4'd3;
  localparam logic [3:0] ST_CALC_C   = 4'd4;
  localparam logic [3:0] ST_SCAN     = 4'd5;
  localparam logic [3:0] ST_DRAIN1   = 4'd6;
  localparam logic [3:0] ST_DRAIN2   = 4'd7;
  localparam logic [3:0] ST_DECIDE   = 4'd8;
  localparam logic [3:0] ST_EM_SEL   = 4'd9;
  localparam logic [3:0] ST_EM_RD    = 4'd10;
  localparam logic [3:0] ST_EM_CAP   = 4'd11;
  localparam logic [3:0] ST_EM_SCAN  = 4'd12;
  localparam logic [3:0] ST_EM_DRAIN = 4'd13;
  localparam logic [3:0] ST_EM_DEC   = 4'd14;
  localparam logic [3:0] ST_FIN      = 4'd15;

  logic [3:0]            state_r, state_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt, cnt_inc, nm1;
  logic [AW-1:0]         i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [MAX_POINTS-1:0] mark_r, mark_nxt;
  logic                  in_xfer, room, i_last, i_pen, j_last, k_last, k_em_last;

  assign in_ready  = (state_r == ST_LOAD);
  assign in_xfer   = in_valid && in_ready;
  assign room      = (cnt_r < CW'(MAX_POINTS));
  assign cnt_inc   = room ? cnt_r + CW'(1) : cnt_r;
  assign nm1       = cnt_r - CW'(1);
  assign i_last    = (CW'(i_r) == nm1);
  assign i_pen     = (CW'(i_r) + CW'(1) == nm1);
  assign j_last    = (CW'(j_r) == nm1);
  assign k_last    = (CW'(k_r) == nm1);
  assign k_em_last = (k_r + AW'(1) == i_r);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    mark_nxt  = mark_r;
    cmd       = '0;
    addr      = '0;

    case (state_r)
      ST_LOAD: begin
        addr       = cnt_r[AW-1:0];
        cmd.wr_en  = in_xfer && room;
        if (in_xfer) begin
          cnt_nxt = cnt_inc;
          i_nxt   = '0;
          j_nxt   = AW'(1);
          if (in_last) begin
            state_nxt = (cnt_inc >= CW'(3)) ? ST_RD_I : ST_EM_SEL;
          end
        end
      end
      ST_RD_I: begin
        addr      = i_r;
        state_nxt = ST_RD_J;
      end
      ST_RD_J: begin
        addr      = j_r;
        cmd.cap_i = 1'b1;
        state_nxt = ST_CAP_J;
      end
      ST_CAP_J: begin
        cmd.cap_j = 1'b1;
        state_nxt = ST_CALC_C;
      end
      ST_CALC_C: begin
        cmd.calc_c = 1'b1;
        k_nxt      = '0;
        state_nxt  = ST_SCAN;
      end
      ST_SCAN: begin
        addr       = k_r;
        cmd.test_v = (k_r != i_r) && (k_r != j_r);
        if (k_last) begin
          state_nxt = ST_DRAIN1;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      ST_DRAIN1: begin
        state_nxt = ST_DRAIN2;
      end
      ST_DRAIN2: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (sts.agree) begin
          mark_nxt[i_r] = 1'b1;
          mark_nxt[j_r] = 1'b1;
        end
        if (j_last) begin
          if (i_pen) begin
            i_nxt     = '0;
            state_nxt = ST_EM_SEL;
          end else begin
            i_nxt     = i_r + AW'(1);
            j_nxt     = i_r + AW'(2);
            state_nxt = ST_RD_I;
          end
        end else begin
          j_nxt     = j_r + AW'(1);
          state_nxt = ST_RD_I;
        end
      end
      // emission: walk marked points in load order
      ST_EM_SEL: begin
        if (mark_r[i_r]) begin
          state_nxt = ST_EM_RD;
        end else if (i_last) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      ST_EM_RD: begin
        addr      = i_r;
        state_nxt = ST_EM_CAP;
      end
      ST_EM_CAP: begin
        cmd.cap_cand = 1'b1;
        k_nxt        = '0;
        state_nxt    = (i_r == '0) ? ST_EM_DEC : ST_EM_SCAN;
      end
      ST_EM_SCAN: begin
        addr        = k_r;
        cmd.dedup_v = mark_r[k_r];
        if (k_em_last) begin
          state_nxt = ST_EM_DRAIN;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      ST_EM_DRAIN: begin
        state_nxt = ST_EM_DEC;
      end
      ST_EM_DEC: begin
        if (sts.dup || !sts.pend_v || sts.out_free) begin
          cmd.push_pend = !sts.dup && sts.pend_v;
          cmd.set_pend  = !sts.dup && !sts.pend_v;
          if (i_last) begin
            state_nxt = ST_FIN;
          end else begin
            i_nxt     = i_r + AW'(1);
            state_nxt = ST_EM_SEL;
          end
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.fin   = 1'b1;
          mark_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      mark_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      mark_r  <= mark_nxt;
    end
  end

endmodule

[hw/rtl/convex_hull_extreme_points_unit.sv]
// Convex hull extreme point unit, top level: controller plus datapath.
// Depends on chep_pkg, chep_if, chep_ctrl, chep_datapath (and chep_ram).
//
//   channel | direction | payload                                   | transfer
//   in_ch   | in        | point_x, point_y, last_point              | valid && ready
//   out_ch  | out       | hull_x, hull_y, no_hull, final_result     | valid && ready
//
// Points load at one per cycle. A set of n >= 3 points then takes n*(n-1)/2
// pairs, each with coefficient reads, one store read per point through the
// single RAM read port and a three-stage side test pipeline, followed by
// emission, which skips unmarked points and compares each marked point i > 0
// with the earlier marked points to drop duplicates, and a closing step.
// Reset (rst_n, synchronous, low) clears marks and count; the store needs none.
// A stalled output holds the emission loop while the next result waits.
module convex_hull_extreme_points_unit
  import chep_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  chep_in_if.sink  in_ch,
  chep_out_if.source out_ch
);

  localparam int AW = $clog2(MAX_POINTS);

  chep_cmd_t     cmd;
  chep_sts_t     sts;
  logic [AW-1:0] addr;
  logic          in_ready;

  assign in_ch.ready = in_ready;

  // Sequencer
  chep_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_point),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  // Store, arithmetic and output register
  chep_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .addr         (addr),
    .in_x         (in_ch.point_x),
    .in_y         (in_ch.point_y),
    .out_ready    (out_ch.ready),
    .sts          (sts),
    .out_valid    (out_ch.valid),
    .hull_x       (out_ch.hull_x),
    .hull_y       (out_ch.hull_y),
    .no_hull      (out_ch.no_hull),
    .final_result (out_ch.final_result)
  );

endmodule

[test/chep_tb_pkg.sv]
`timescale 1ns / 1ps
// Testbench package for the convex hull extreme point unit: the result record
// and a scoreboard that predicts each set's hull points and checks them.
// Depends on chep_pkg.
package chep_tb_pkg;
  import chep_pkg::*;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   no_hull;
    logic   final_result;
  } hull_vertex_t;

  class hull_scoreboard;
    coord_t       set_x[MAX_POINTS_DEF];
    coord_t       set_y[MAX_POINTS_DEF];
    int unsigned  set_len;
    hull_vertex_t expected_q[$];
    int unsigned  errors;

    function new();
      set_len = 0;
      errors  = 0;
    endfunction

    // One accepted point; on the last flag the set is evaluated
    function void note_point(coord_t x, coord_t y, logic last);
      bit           on_hull[MAX_POINTS_DEF];
      longint       a, b, c, s;
      bit           seen, first_neg, agree, neg, dup;
      int unsigned  emitted;
      hull_vertex_t r;
      // points past the store depth are dropped, but a last flag still counts
      if (set_len < MAX_POINTS_DEF) begin
        set_x[set_len] = x;
        set_y[set_len] = y;
        set_len++;
      end
      if (!last) return;

      for (int i = 0; i < MAX_POINTS_DEF; i++) on_hull[i] = 1'b0;

      // every pair is a candidate edge; all others must sit on one side
      if (set_len >= 3) begin
        for (int i = 0; i + 1 < set_len; i++) begin
          for (int j = i + 1; j < set_len; j++) begin
            a = longint'(set_y[j]) - longint'(set_y[i]);
            b = longint'(set_x[i]) - longint'(set_x[j]);
            c = longint'(set_x[i]) * longint'(set_y[j])
                - longint'(set_y[i]) * longint'(set_x[j]);
            seen      = 1'b0;
            first_neg = 1'b0;
            agree     = 1'b1;
            for (int k = 0; k < set_len; k++) begin
              if (k == i || k == j) continue;
              s   = a * longint'(set_x[k]) + b * longint'(set_y[k]) - c;
              neg = (s < 0);
              if (!seen) begin
                seen      = 1'b1;
                first_neg = neg;
              end else if (neg != first_neg) begin
                agree = 1'b0;
              end
            end
            if (agree) begin
              on_hull[i] = 1'b1;
              on_hull[j] = 1'b1;
            end
          end
        end
      end

      // marked points in load order, repeated coordinates only once
      emitted = 0;
      for (int i = 0; i < set_len; i++) begin
        if (!on_hull[i]) continue;
        dup = 1'b0;
        for (int e = 0; e < i; e++) begin
          if (on_hull[e] && set_x[e] == set_x[i] && set_y[e] == set_y[i]) dup = 1'b1;
        end
        if (dup) continue;
        r.x            = set_x[i];
        r.y            = set_y[i];
        r.no_hull      = 1'b0;
        r.final_result = 1'b0;
        expected_q.insert(expected_q.size(), r);
        emitted++;
      end

      if (emitted == 0) begin
        r.x            = '0;
        r.y            = '0;
        r.no_hull      = 1'b1;
        r.final_result = 1'b1;
        expected_q.insert(expected_q.size(), r);
      end else begin
        expected_q[expected_q.size()-1].final_result = 1'b1;
      end
      set_len = 0;
    endfunction

    // One result transfer against the oldest expected hull point
    function void check_result(hull_vertex_t got);
      hull_vertex_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d no_hull=%0b final=%0b",
                 $time, got.x, got.y, got.no_hull, got.final_result);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x) begin
        $display("%0t: hull_x expected %0d actual %0d", $time, want.x, got.x);
        errors++;
      end
      if (got.y !== want.y) begin
        $display("%0t: hull_y expected %0d actual %0d", $time, want.y, got.y);
        errors++;
      end
      if (got.no_hull !== want.no_hull) begin
        $display("%0t: no_hull expected %0b actual %0b", $time, want.no_hull, got.no_hull);
        errors++;
      end
      if (got.final_result !== want.final_result) begin
        $display("%0t: final_result expected %0b actual %0b",
                 $time, want.final_result, got.final_result);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_q.size();
    endfunction
  endclass

endpackage

[test/tb_convex_hull_extreme_points_unit.sv]
`timescale 1ns / 1ps
// Top-level testbench for convex_hull_extreme_points_unit: directed and random
// point sets with random idling on both channels, checked by the scoreboard.
// Depends on chep_pkg, chep_if, chep_tb_pkg and the unit's RTL.
module tb_convex_hull_extreme_points_unit;
  import chep_pkg::*;
  import chep_tb_pkg::*;

  // watchdog limit; runs stay far below this
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned RANDOM_POINTS = 470;
  localparam int unsigned DRAIN_CYCLES  = 400;

  typedef enum int {
    SPREAD_WIDE,
    SPREAD_GRID,
    SPREAD_CORNER,
    SPREAD_LINE
  } point_spread_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned points_sent = 0;
  bit          calm_in     = 1'b0;
  bit          calm_out    = 1'b0;
  coord_t      pend_x[$];
  coord_t      pend_y[$];

  hull_scoreboard hull_sb;

  chep_in_if  #(.COORD_BITS(COORD_BITS_DEF)) in_ch ();
  chep_out_if #(.COORD_BITS(COORD_BITS_DEF)) out_ch ();

  convex_hull_extreme_points_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result transfers go straight to the scoreboard
  always @(posedge clk) begin
    hull_vertex_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.x            = out_ch.hull_x;
      got.y            = out_ch.hull_y;
      got.no_hull      = out_ch.no_hull;
      got.final_result = out_ch.final_result;
      hull_sb.check_result(got);
    end
  end

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = calm_out ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one point transfer; entered and left at a falling edge
  task automatic send_point(coord_t x, coord_t y, logic last);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      // junk payload while idle must be ignored
      in_ch.valid      = 1'b0;
      in_ch.point_x    = coord_t'($urandom);
      in_ch.point_y    = coord_t'($urandom);
      in_ch.last_point = 1'($urandom_range(0, 1));
      repeat (gap) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.point_x    = x;
    in_ch.point_y    = y;
    in_ch.last_point = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hull_sb.note_point(x, y, last);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic queue_point(int x, int y);
    pend_x.insert(pend_x.size(), coord_t'(x));
    pend_y.insert(pend_y.size(), coord_t'(y));
  endtask

  // sends the queued points as one set, last flag on the final one
  task automatic send_set();
    for (int i = 0; i < pend_x.size(); i++)
      send_point(pend_x[i], pend_y[i], i == pend_x.size() - 1);
    pend_x.delete();
    pend_y.delete();
  endtask

  function automatic coord_t draw_coord(point_spread_t spread);
    int v;
    case (spread)
      SPREAD_GRID: v = int'($urandom_range(0, 8)) - 4;
      SPREAD_CORNER: begin
        if ($urandom_range(0, 1)) v = 32767 - int'($urandom_range(0, 3));
        else v = -32768 + int'($urandom_range(0, 3));
      end
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return coord_t'(v);
  endfunction

  // stimulus
  initial begin
    int unsigned   target, set_size, pick;
    point_spread_t spread;
    int            base_x, base_y, step_x, step_y, t;

    hull_sb          = new();
    in_ch.valid      = 1'b0;
    in_ch.point_x    = '0;
    in_ch.point_y    = '0;
    in_ch.last_point = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // single point: no hull
    queue_point(32767, -32768);
    send_set();
    // two points: no hull
    queue_point(-32768, 32767);
    queue_point(0, 0);
    send_set();
    // full-range triangle
    queue_point(-32768, -32768);
    queue_point(32767, -32768);
    queue_point(0, 32767);
    send_set();
    // square with an interior point and a repeated corner
    queue_point(32767, 32767);
    queue_point(-32768, 32767);
    queue_point(-32768, -32768);
    queue_point(32767, -32768);
    queue_point(0, 0);
    queue_point(32767, 32767);
    send_set();
    // collinear points
    queue_point(1, 1);
    queue_point(2, 2);
    queue_point(3, 3);
    queue_point(-5, -5);
    send_set();
    // identical points collapse to one result
    queue_point(7, -7);
    queue_point(7, -7);
    queue_point(7, -7);
    send_set();

    // random sets, mostly small; a few fill or overflow the store
    target = points_sent + RANDOM_POINTS;
    while (points_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 8)       set_size = $urandom_range(1, 2);
      else if (pick < 88) set_size = $urandom_range(3, 7);
      else if (pick < 96) set_size = $urandom_range(8, MAX_POINTS_DEF);
      else                set_size = $urandom_range(MAX_POINTS_DEF + 1, MAX_POINTS_DEF + 4);
      spread   = point_spread_t'($urandom_range(0, 3));
      calm_in  = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      base_x   = int'($urandom_range(0, 400)) - 200;
      base_y   = int'($urandom_range(0, 400)) - 200;
      step_x   = int'($urandom_range(0, 6)) - 3;
      step_y   = int'($urandom_range(0, 6)) - 3;
      for (int i = 0; i < set_size; i++) begin
        if (spread == SPREAD_LINE) begin
          t = int'($urandom_range(0, 120)) - 60;
          queue_point(base_x + t * step_x, base_y + t * step_y);
        end else if (spread == SPREAD_CORNER && $urandom_range(0, 1)) begin
          // corners mixed with spread points
          queue_point(int'(draw_coord(SPREAD_WIDE)), int'(draw_coord(SPREAD_CORNER)));
        end else begin
          queue_point(int'(draw_coord(spread)), int'(draw_coord(spread)));
        end
      end
      send_set();
    end
    in_ch.valid = 1'b0;

    // drain, then allow time for any stray result
    while (hull_sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (hull_sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
